FILE: rtl/pgi_pkg.sv
package pgi_pkg;

  localparam int PGI_DEPTH = 1024;
  localparam int PGI_VALUE_WIDTH = 32;
  localparam int PGI_SAMPLE_W = 32;
  localparam int PGI_PREV_W = 11;

  // Index reported when no earlier value qualifies, or on overflow.
  localparam logic signed [PGI_PREV_W-1:0] PGI_NO_INDEX = '1;

  typedef struct packed {
    logic signed [PGI_SAMPLE_W-1:0] sample_value;
    logic                           start_flag;
  } pgi_req_t;

  typedef struct packed {
    logic signed [PGI_PREV_W-1:0] prev_index;
    logic                         overflow;
  } pgi_rsp_t;

endpackage

FILE: rtl/pgi_store.sv
module pgi_store #(
  parameter int WORD_W = 44,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/previous_greater_index.sv
// Previous greater-or-equal index search over a stored sequence.
// The first item of a sequence and an overflow item are answered straight
// from the request; any other item reads the value/link store, through its
// single read port, for the entry below it and once more per back-link hop.
// Takes one item at a time. Reset clears the sequence length and the
// sequencer; the store itself is not cleared.
module previous_greater_index
  import pgi_pkg::*;
#(
  parameter int DEPTH = PGI_DEPTH,
  parameter int VALUE_WIDTH = PGI_VALUE_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  pgi_req_t req_data,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output pgi_rsp_t rsp_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LINK_W = IDX_W + 1;
  localparam int WORD_W = VALUE_WIDTH + LINK_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  logic [1:0]             state;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       ptr;
  logic [VALUE_WIDTH-1:0] key;

  logic                   rsp_free;
  logic                   rsp_load;
  logic                   accept;
  logic [CNT_W-1:0]       base_count;
  logic [CNT_W-1:0]       base_less;
  logic                   base_full;
  logic                   base_first;
  logic [VALUE_WIDTH-1:0] req_raw;
  logic [VALUE_WIDTH-1:0] req_key;

  logic [WORD_W-1:0]      rd_word;
  logic [VALUE_WIDTH-1:0] rd_key;
  logic                   rd_has_link;
  logic [IDX_W-1:0]       rd_link;
  logic                   hit;
  logic                   finish;
  logic                   advance;
  logic [LINK_W-1:0]      found_link;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [WORD_W-1:0]      wr_data;
  logic [IDX_W-1:0]       rd_addr;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && rsp_free;
  assign accept    = req_valid && req_ready;

  assign base_count = req_data.start_flag ? '0 : count;
  assign base_less  = base_count - 1'b1;
  assign base_full  = base_count >= CNT_W'(DEPTH);
  assign base_first = base_count == '0;

  // Flipping the sign bit gives an unsigned key with the same order.
  assign req_raw = VALUE_WIDTH'($unsigned(req_data.sample_value));
  assign req_key = {~req_raw[VALUE_WIDTH-1], req_raw[VALUE_WIDTH-2:0]};

  assign rd_key      = rd_word[WORD_W-1 -: VALUE_WIDTH];
  assign rd_has_link = rd_word[LINK_W-1];
  assign rd_link     = rd_word[IDX_W-1:0];

  assign hit        = rd_key >= key;
  assign finish     = (state == S_CMP) && (hit || !rd_has_link);
  assign advance    = (state == S_CMP) && !hit && rd_has_link;
  assign found_link = hit ? {1'b1, ptr} : '0;

  // A new result is loaded either straight from an accepted request or when
  // the link walk ends.
  assign rsp_load = (accept && (base_full || base_first)) || (finish && rsp_free);

  // While following links the next address comes straight from the stored
  // link rather than from the registered pointer.
  assign rd_addr = advance ? rd_link : ptr;

  always_comb begin
    if (state == S_CMP) begin
      wr_en   = finish && rsp_free;
      wr_addr = idx;
      wr_data = {key, found_link};
    end else begin
      wr_en   = accept && !base_full && base_first;
      wr_addr = '0;
      wr_data = {req_key, {LINK_W{1'b0}}};
    end
  end

  pgi_store #(
    .WORD_W (WORD_W),
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (base_full) begin
              count                <= CNT_W'(DEPTH);
              rsp_data.prev_index  <= PGI_NO_INDEX;
              rsp_data.overflow    <= 1'b1;
            end else if (base_first) begin
              count                <= CNT_W'(1);
              rsp_data.prev_index  <= PGI_NO_INDEX;
              rsp_data.overflow    <= 1'b0;
            end else begin
              idx   <= base_count[IDX_W-1:0];
              ptr   <= base_less[IDX_W-1:0];
              key   <= req_key;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (advance) begin
            ptr <= rd_link;
          end else if (rsp_free) begin
            count                <= CNT_W'(idx) + 1'b1;
            rsp_data.prev_index  <= hit ? $signed(PGI_PREV_W'(ptr)) : PGI_NO_INDEX;
            rsp_data.overflow    <= 1'b0;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("sequence length exceeds store depth");

  a_walk_below: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (ptr < idx))
    else $error("link walk reached an entry at or above the current index");

  a_overflow_none: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.overflow) |-> (rsp_data.prev_index == PGI_NO_INDEX))
    else $error("overflow result carries an index");

  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    (accept && !base_full && !base_first) |=> (state == S_READ))
    else $error("search did not start after a stored request");
`endif

endmodule

FILE: tb/testbench.sv
module testbench;
  import pgi_pkg::*;

  localparam int N_SAMPLES = 1650;
  localparam int PHASE_LEN = 150;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;

  localparam logic signed [PGI_SAMPLE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [PGI_SAMPLE_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum int {VAL_WIDE, VAL_NARROW, VAL_FALLING, VAL_RISING, VAL_EXTREME} value_style_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_phase_e;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  pgi_req_t req_data = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  pgi_rsp_t rsp_data;

  previous_greater_index u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  always #1 clk = ~clk;

  pgi_req_t pending_samples[$];
  pgi_rsp_t expected_indices[$];

  // Mirror of the sequence held by the block: values and their back-links.
  logic signed [PGI_SAMPLE_W-1:0] seen_value [PGI_DEPTH];
  int back_link [PGI_DEPTH];
  int seq_len = 0;

  int   n_taken = 0;
  int   n_checked = 0;
  int   n_overflow = 0;
  int   n_sequences = 1;
  int   n_errors = 0;
  int   top_index = -1;
  logic req_taken = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  function automatic pgi_rsp_t search_prev_greater(pgi_req_t r);
    pgi_rsp_t rsp;
    int j;
    rsp.overflow = 1'b0;
    rsp.prev_index = PGI_NO_INDEX;
    if (r.start_flag) begin
      seq_len = 0;
      n_sequences++;
    end
    if (seq_len >= PGI_DEPTH) begin
      seq_len = PGI_DEPTH;
      rsp.overflow = 1'b1;
      return rsp;
    end
    // Walk the back-links, skipping every run of smaller values at once.
    j = seq_len - 1;
    while (j >= 0 && $signed(seen_value[j]) < $signed(r.sample_value)) begin
      j = back_link[j];
    end
    seen_value[seq_len] = r.sample_value;
    back_link[seq_len] = j;
    seq_len++;
    rsp.prev_index = j[PGI_PREV_W-1:0];
    return rsp;
  endfunction

  function automatic int idle_pct(bit receiver_side);
    idle_phase_e phase;
    phase = idle_phase_e'((n_taken / PHASE_LEN) % 4);
    case (phase)
      IDLE_SENDER: return receiver_side ? 0 : 70;
      IDLE_RECEIVER: return receiver_side ? 70 : 0;
      IDLE_BOTH: return 34;
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [PGI_SAMPLE_W-1:0] pick_value(value_style_e style, int pos);
    logic signed [PGI_SAMPLE_W-1:0] v;
    case (style)
      VAL_NARROW: v = $signed($urandom_range(0, 15)) - 8;
      VAL_FALLING: begin
        // Mostly falling with some jitter, plus rare spikes that walk far back.
        if ($urandom_range(0, 99) < 4) v = $urandom;
        else v = 32'sd2_000_000 - pos * 100 + $urandom_range(0, 150);
      end
      VAL_RISING: v = -32'sd2_000_000 + pos * 100 - $urandom_range(0, 150);
      VAL_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = '0;
          3: v = -1;
          default: v = $urandom;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic push_sample(logic signed [PGI_SAMPLE_W-1:0] value, logic start);
    pgi_req_t r;
    r.sample_value = value;
    r.start_flag = start;
    pending_samples.push_back(r);
  endtask

  task automatic push_run(int len, value_style_e style, bit noisy);
    logic start;
    for (int i = 0; i < len; i++) begin
      if (!noisy) start = (i == 0);
      else if (i == 0) start = ($urandom_range(0, 19) != 0);
      else start = ($urandom_range(0, 49) == 0);
      push_sample(pick_value(style, i), start);
    end
  endtask

  // Driver: a new request is offered only once the current one was taken.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
        req_valid <= 1'b1;
        req_data <= pending_samples.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // One long hold-off on the result side so the block backs up into its input.
  always @(negedge clk) begin
    if (!rst && !hold_done && n_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  always @(posedge clk) begin
    pgi_rsp_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && req_ready;
      if (req_valid && req_ready) begin
        expected_indices.push_back(search_prev_greater(req_data));
        n_taken++;
      end
      if (rsp_valid && rsp_ready) begin
        n_checked++;
        if (rsp_data.overflow === 1'b1) n_overflow++;
        else if ($signed(rsp_data.prev_index) > top_index) top_index = $signed(rsp_data.prev_index);
        if (expected_indices.size() == 0) begin
          $error("result with no request pending: prev_index %0d, overflow %0b",
                 rsp_data.prev_index, rsp_data.overflow);
          n_errors++;
        end else begin
          want = expected_indices.pop_front();
          if (rsp_data.prev_index !== want.prev_index) begin
            $error("prev_index: expected %0d, got %0d", want.prev_index, rsp_data.prev_index);
            n_errors++;
          end
          if (rsp_data.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, rsp_data.overflow);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    int run_len;
    value_style_e style;
    bit long_done;
    long_done = 1'b0;

    // The first item continues the sequence that began at reset.
    push_sample(32'sd5, 1'b0);
    push_sample(32'sd3, 1'b0);
    push_sample(32'sd5, 1'b0);
    push_sample(VAL_MAX, 1'b0);
    push_sample(VAL_MIN, 1'b0);
    push_sample(VAL_MIN, 1'b0);
    push_sample(32'sd0, 1'b0);
    push_sample(-32'sd1, 1'b0);
    push_sample(32'sh5555_5555, 1'b0);
    push_sample(32'shAAAA_AAAA, 1'b0);
    push_sample(VAL_MIN, 1'b1);
    push_sample(VAL_MAX, 1'b0);
    push_sample(VAL_MAX, 1'b1);
    push_sample(VAL_MAX, 1'b0);
    push_sample(32'sd100, 1'b1);
    push_sample(32'sd50, 1'b0);
    push_sample(32'sd25, 1'b0);
    push_sample(32'sd10, 1'b0);
    push_sample(32'sd75, 1'b0);
    push_sample(32'sd200, 1'b0);
    push_sample(-32'sd7, 1'b1);
    push_sample(-32'sd7, 1'b1);

    while (pending_samples.size() < N_SAMPLES) begin
      if (!long_done && pending_samples.size() > 200) begin
        // A single sequence that runs past the store depth.
        push_run(PGI_DEPTH + $urandom_range(3, 8), VAL_FALLING, 1'b0);
        long_done = 1'b1;
      end else begin
        run_len = $urandom_range(1, 40);
        style = value_style_e'($urandom_range(0, 4));
        push_run(run_len, style, 1'b1);
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_samples.size() != 0 || req_valid) @(posedge clk);
    while (expected_indices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests over %0d sequences; %0d results were past the store depth.",
             n_taken, n_sequences, n_overflow);
    $display("Highest index reported %0d; %0d results checked, %0d mismatches.",
             top_index, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still expected.", expected_indices.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
